[hw/rtl/nmf_pkg.sv]
`default_nettype none

package nmf_pkg;

	localparam int unsigned MAX_WIDTH  = 1024;
	localparam int unsigned MAX_HEIGHT = 1024;
	localparam int unsigned PIXEL_BITS = 8;
	localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int unsigned SIZE_BITS  = 11;
	localparam int unsigned ADDR_BITS  = 3;
	localparam int unsigned DATA_BITS  = 32;
	localparam int unsigned NBR_COUNT  = 8;
	localparam int unsigned MEDIAN_POS = 4;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef pixel_t [NBR_COUNT-1:0] nbr_vec_t;
	typedef pixel_t [8:0] window_t;
	typedef logic [COL_BITS-1:0] col_t;
	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [SIZE_BITS-1:0] size_t;

	// item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// register indexes (byte address bit 2)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// where a non-median output value comes from
	typedef logic [1:0] src_t;
	localparam src_t SRC_CENTER = 2'd0;
	localparam src_t SRC_PREV   = 2'd1;
	localparam src_t SRC_OLDER  = 2'd2;
	localparam src_t SRC_RECENT = 2'd3;

	typedef struct packed {
		logic   op;
		pixel_t pixel_in;
	} in_item_t;

	typedef struct packed {
		pixel_t pixel_out;
		row_t   out_row;
		col_t   out_col;
		logic   frame_end;
	} out_item_t;

	typedef struct packed {
		logic   med;
		pixel_t value;
		row_t   row;
		col_t   col;
		logic   frame_end;
	} meta_t;

	function automatic nbr_vec_t cmp_swap(input nbr_vec_t v, input logic [2:0] lo,
		input logic [2:0] hi);
		nbr_vec_t r;
		r = v;
		if (v[lo] > v[hi]) begin
			r[lo] = v[hi];
			r[hi] = v[lo];
		end
		return r;
	endfunction

	// odd-even merge sort of eight values, two comparator layers per stage
	function automatic nbr_vec_t sort_part_a(input nbr_vec_t v);
		nbr_vec_t r;
		r = v;
		r = cmp_swap(r, 3'd0, 3'd1);
		r = cmp_swap(r, 3'd2, 3'd3);
		r = cmp_swap(r, 3'd4, 3'd5);
		r = cmp_swap(r, 3'd6, 3'd7);
		r = cmp_swap(r, 3'd0, 3'd2);
		r = cmp_swap(r, 3'd1, 3'd3);
		r = cmp_swap(r, 3'd4, 3'd6);
		r = cmp_swap(r, 3'd5, 3'd7);
		return r;
	endfunction

	function automatic nbr_vec_t sort_part_b(input nbr_vec_t v);
		nbr_vec_t r;
		r = v;
		r = cmp_swap(r, 3'd1, 3'd2);
		r = cmp_swap(r, 3'd5, 3'd6);
		r = cmp_swap(r, 3'd0, 3'd4);
		r = cmp_swap(r, 3'd1, 3'd5);
		r = cmp_swap(r, 3'd2, 3'd6);
		r = cmp_swap(r, 3'd3, 3'd7);
		return r;
	endfunction

	function automatic nbr_vec_t sort_part_c(input nbr_vec_t v);
		nbr_vec_t r;
		r = v;
		r = cmp_swap(r, 3'd2, 3'd4);
		r = cmp_swap(r, 3'd3, 3'd5);
		r = cmp_swap(r, 3'd1, 3'd2);
		r = cmp_swap(r, 3'd3, 3'd4);
		r = cmp_swap(r, 3'd5, 3'd6);
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/neighbour_median_filter_3x3_unit.sv]
`default_nettype none

// 3x3 neighbour median filter on a raster pixel stream. One item (pixel or drain
// tick) is taken per clock; the pipeline from acceptance to the output register
// only pauses while that register holds a result that is being stalled. Two
// 1024x8 line memories (one read port, registered read data, older-line write
// forwarded to a read of the same column in the same cycle) hold the two rows
// above the input row. Interior outputs are the upper median of the eight
// neighbours, border pixels are copied, and each output lags its input by width+1
// pixels; the outputs still owed at frame end leave one per drain tick, and pixel
// items are dropped until they have all left. Writing either size register
// restarts the frame. Sizes of 0 are used as 1 and sizes above 1024 as 1024.
module neighbour_median_filter_3x3_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  nmf_pkg::in_item_t                    in_item,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output nmf_pkg::out_item_t                   out_item,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [nmf_pkg::ADDR_BITS-1:0]        paddr,
	input  wire  [nmf_pkg::DATA_BITS-1:0]        pwdata,
	output logic [nmf_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready
);

	localparam int unsigned SB = nmf_pkg::SIZE_BITS;
	localparam int unsigned CB = nmf_pkg::COL_BITS;
	localparam int unsigned RB = nmf_pkg::ROW_BITS;

	// configuration
	nmf_pkg::size_t image_width_q, image_height_q;
	nmf_pkg::size_t w_eff, h_eff;
	nmf_pkg::col_t  w_last;
	nmf_pkg::row_t  h_last;
	logic           cfg_we;

	// input-side state
	nmf_pkg::row_t  in_row_q, dr_row_q;
	nmf_pkg::col_t  in_col_q, dr_col_q;
	nmf_pkg::size_t pending_q;

	// line memories
	nmf_pkg::pixel_t older_mem [nmf_pkg::MAX_WIDTH];
	nmf_pkg::pixel_t recent_mem [nmf_pkg::MAX_WIDTH];

	// handshake and stage-0 decode
	logic           adv, accept, is_pix, act, res0, med0, fe0;
	nmf_pkg::src_t  src0;
	nmf_pkg::row_t  row0;
	nmf_pkg::col_t  col0, rd_addr;

	// stage 1
	logic            v_s1, res_s1, pix_s1, med_s1, fe_s1, fwd_s1;
	nmf_pkg::src_t   src_s1;
	nmf_pkg::row_t   row_s1;
	nmf_pkg::col_t   col_s1, addr_s1;
	nmf_pkg::pixel_t older_rd_s1, recent_rd_s1, fwd_val_s1;
	nmf_pkg::pixel_t p_s1;
	nmf_pkg::pixel_t a1, b1, val1;
	nmf_pkg::window_t window_q, win_next;
	nmf_pkg::pixel_t prev_b_q;
	nmf_pkg::nbr_vec_t nbr1;

	// sort stages
	logic              v_s2, v_s3, v_s4;
	nmf_pkg::nbr_vec_t vec_s2, vec_s3, vec_s4, vec_fin;
	nmf_pkg::meta_t    meta_s2, meta_s3, meta_s4;

	// output register
	logic               out_valid_q;
	nmf_pkg::out_item_t out_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = SB'(1);
		end else if (image_width_q > SB'(nmf_pkg::MAX_WIDTH)) begin
			w_eff = SB'(nmf_pkg::MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q == '0) begin
			h_eff = SB'(1);
		end else if (image_height_q > SB'(nmf_pkg::MAX_HEIGHT)) begin
			h_eff = SB'(nmf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
	end

	assign w_last = CB'(w_eff - SB'(1));
	assign h_last = RB'(h_eff - SB'(1));

	always_comb begin
		if (paddr[2] == nmf_pkg::REG_HEIGHT) begin
			prdata = {{(nmf_pkg::DATA_BITS-SB){1'b0}}, image_height_q};
		end else begin
			prdata = {{(nmf_pkg::DATA_BITS-SB){1'b0}}, image_width_q};
		end
	end

	// ---------------- stage 0: accept and decode ----------------
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign is_pix   = (in_item.op == nmf_pkg::OP_PIXEL);
	// pixel items are dropped while drain outputs are owed; drains need something owed
	assign act      = accept && (is_pix ? (pending_q == '0) : (pending_q != '0));
	assign rd_addr  = is_pix ? in_col_q : dr_col_q;

	always_comb begin
		res0 = 1'b0;
		med0 = 1'b0;
		fe0  = 1'b0;
		src0 = nmf_pkg::SRC_CENTER;
		row0 = in_row_q;
		col0 = in_col_q;
		if (is_pix) begin
			res0 = (in_row_q >= RB'(2)) || ((in_row_q == RB'(1)) && (in_col_q != '0));
			if (in_col_q == '0) begin
				// last column of two rows up: older-line value written by the previous pixel
				row0 = in_row_q - RB'(2);
				col0 = w_last;
				src0 = nmf_pkg::SRC_PREV;
			end else begin
				row0 = in_row_q - RB'(1);
				col0 = in_col_q - CB'(1);
				med0 = (row0 != '0) && (col0 != '0)
					&& (({2'b00, row0} + 12'd2) <= {1'b0, h_eff})
					&& (({2'b00, col0} + 12'd2) <= {1'b0, w_eff});
			end
		end else begin
			res0 = 1'b1;
			row0 = dr_row_q;
			col0 = dr_col_q;
			fe0  = (pending_q == SB'(1));
			src0 = (({1'b0, dr_row_q} + SB'(1)) == h_eff) ? nmf_pkg::SRC_RECENT
				: nmf_pkg::SRC_OLDER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SB'(nmf_pkg::MAX_WIDTH);
			image_height_q <= SB'(nmf_pkg::MAX_HEIGHT);
			in_row_q       <= '0;
			in_col_q       <= '0;
			pending_q      <= '0;
			dr_row_q       <= '0;
			dr_col_q       <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == nmf_pkg::REG_HEIGHT) begin
				image_height_q <= pwdata[SB-1:0];
			end else begin
				image_width_q <= pwdata[SB-1:0];
			end
			in_row_q  <= '0;
			in_col_q  <= '0;
			pending_q <= '0;
		end else if (act) begin
			if (is_pix) begin
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					if (in_row_q == h_last) begin
						in_row_q <= '0;
						// a one-row frame owes every pixel, otherwise width+1 of them
						if (h_eff == SB'(1)) begin
							pending_q <= w_eff;
							dr_row_q  <= '0;
							dr_col_q  <= '0;
						end else begin
							pending_q <= w_eff + SB'(1);
							dr_row_q  <= h_last - RB'(1);
							dr_col_q  <= w_last;
						end
					end else begin
						in_row_q <= in_row_q + RB'(1);
					end
				end else begin
					in_col_q <= in_col_q + CB'(1);
				end
			end else begin
				pending_q <= pending_q - SB'(1);
				if (dr_col_q == w_last) begin
					dr_col_q <= '0;
					dr_row_q <= dr_row_q + RB'(1);
				end else begin
					dr_col_q <= dr_col_q + CB'(1);
				end
			end
		end
	end

	// ---------------- line memories ----------------
	always_ff @(posedge clk) begin
		if (act) begin
			recent_rd_s1 <= recent_mem[rd_addr];
		end
		if (act && is_pix) begin
			recent_mem[in_col_q] <= in_item.pixel_in;
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			older_rd_s1 <= older_mem[rd_addr];
		end
		if (adv && v_s1 && pix_s1) begin
			older_mem[addr_s1] <= b1;
		end
	end

	// ---------------- stage 1: window update and value select ----------------
	assign a1 = fwd_s1 ? fwd_val_s1 : older_rd_s1;
	assign b1 = recent_rd_s1;

	always_comb begin
		win_next    = window_q;
		win_next[0] = window_q[1];
		win_next[1] = window_q[2];
		win_next[2] = a1;
		win_next[3] = window_q[4];
		win_next[4] = window_q[5];
		win_next[5] = b1;
		win_next[6] = window_q[7];
		win_next[7] = window_q[8];
		win_next[8] = p_s1;
	end

	assign nbr1 = {win_next[8], win_next[7], win_next[6], win_next[5],
		win_next[3], win_next[2], win_next[1], win_next[0]};

	always_comb begin
		unique case (src_s1)
			nmf_pkg::SRC_CENTER: val1 = win_next[4];
			nmf_pkg::SRC_PREV:   val1 = prev_b_q;
			nmf_pkg::SRC_OLDER:  val1 = a1;
			nmf_pkg::SRC_RECENT: val1 = b1;
			default:             val1 = win_next[4];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			fwd_s1   <= 1'b0;
			window_q <= '0;
		end else if (adv) begin
			v_s1 <= act;
			if (act) begin
				// older-line write of the item now leaving stage 1 lands after this read
				fwd_s1 <= v_s1 && pix_s1 && (addr_s1 == rd_addr);
			end
			if (v_s1 && pix_s1) begin
				window_q <= win_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && act) begin
			fwd_val_s1 <= b1;
			res_s1     <= res0;
			pix_s1     <= is_pix;
			med_s1     <= med0;
			fe_s1      <= fe0;
			src_s1     <= src0;
			row_s1     <= row0;
			col_s1     <= col0;
			addr_s1    <= rd_addr;
			p_s1       <= in_item.pixel_in;
		end
		if (adv && v_s1 && pix_s1) begin
			prev_b_q <= b1;
		end
	end

	// ---------------- stages 2 to 4: sorting network ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && res_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s2            <= nbr1;
			meta_s2.med       <= med_s1;
			meta_s2.value     <= val1;
			meta_s2.row       <= row_s1;
			meta_s2.col       <= col_s1;
			meta_s2.frame_end <= fe_s1;
			vec_s3            <= nmf_pkg::sort_part_a(vec_s2);
			meta_s3           <= meta_s2;
			vec_s4            <= nmf_pkg::sort_part_b(vec_s3);
			meta_s4           <= meta_s3;
		end
	end

	assign vec_fin = nmf_pkg::sort_part_c(vec_s4);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			out_q.pixel_out <= meta_s4.med ? vec_fin[nmf_pkg::MEDIAN_POS] : meta_s4.value;
			out_q.out_row   <= meta_s4.row;
			out_q.out_col   <= meta_s4.col;
			out_q.frame_end <= meta_s4.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

[test/nmf_filter_check.sv]
module nmf_filter_check
	import nmf_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_stall,
	input  in_item_t             in_item,
	input  wire                  out_valid,
	input  wire                  out_stall,
	input  out_item_t            out_item,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire                  pready,
	input  wire [ADDR_BITS-1:0]  paddr,
	input  wire [DATA_BITS-1:0]  pwdata,
	output int unsigned          mismatches,
	output int unsigned          waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	size_t       width_reg;
	size_t       height_reg;
	pixel_t      older_row [MAX_WIDTH];
	pixel_t      recent_row [MAX_WIDTH];
	window_t     win;
	int unsigned next_row;
	int unsigned next_col;
	int unsigned drains_owed;
	int unsigned fail_tally;
	out_item_t   expected_pixels [$];

	function automatic int unsigned usable_size(input size_t v, input int unsigned limit_size);
		if (v == 0)
			return 1;
		if (v > limit_size)
			return limit_size;
		return {21'd0, v};
	endfunction

	// fifth smallest of the eight pixels around the centre
	function automatic pixel_t neighbour_rank5(input window_t w);
		nbr_vec_t v;
		pixel_t   x;
		int       j;
		int       n;
		n = 0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				v[n] = w[i];
				n++;
			end
		end
		for (int i = 1; i < NBR_COUNT; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		return v[MEDIAN_POS];
	endfunction

	task automatic predict_item(input in_item_t it);
		int unsigned w, h, total, r, c, ic, ir, n;
		pixel_t      a, b, last_old, val;
		out_item_t   e;
		w = usable_size(width_reg, MAX_WIDTH);
		h = usable_size(height_reg, MAX_HEIGHT);
		total = w * h;
		if (it.op == OP_DRAIN) begin
			if (drains_owed == 0)
				return;
			r = (total - drains_owed) / w;
			c = (total - drains_owed) % w;
			drains_owed--;
			// the last row sits in the recent line, everything before it in the older one
			e.pixel_out = (r + 1 == h) ? recent_row[c] : older_row[c];
			e.out_row = row_t'(r);
			e.out_col = col_t'(c);
			e.frame_end = (drains_owed == 0);
			expected_pixels.push_back(e);
			return;
		end
		if (drains_owed != 0)
			return;
		ic = next_col;
		ir = next_row;
		n = ir * w + ic;
		last_old = older_row[w-1];
		a = older_row[ic];
		b = recent_row[ic];
		older_row[ic] = b;
		recent_row[ic] = it.pixel_in;
		for (int q = 0; q < 9; q += 3) begin
			win[q] = win[q+1];
			win[q+1] = win[q+2];
		end
		win[2] = a;
		win[5] = b;
		win[8] = it.pixel_in;
		if (n >= w + 1) begin
			if (ic == 0) begin
				// output wraps back to the last column two rows up
				r = ir - 2;
				c = w - 1;
				val = last_old;
			end else begin
				r = ir - 1;
				c = ic - 1;
				if (r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w)
					val = neighbour_rank5(win);
				else
					val = win[4];
			end
			e.pixel_out = val;
			e.out_row = row_t'(r);
			e.out_col = col_t'(c);
			e.frame_end = (n - w == total);
			expected_pixels.push_back(e);
		end
		if (ic + 1 >= w) begin
			next_col = 0;
			if (ir + 1 >= h) begin
				next_row = 0;
				drains_owed = (total < w + 1) ? total : w + 1;
			end else begin
				next_row = ir + 1;
			end
		end else begin
			next_col = ic + 1;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t e;
		if (expected_pixels.size() == 0) begin
			fail_tally++;
			$display("%0t: unexpected result pixel %0d row %0d col %0d end %0b", $time,
				got.pixel_out, got.out_row, got.out_col, got.frame_end);
			return;
		end
		e = expected_pixels.pop_front();
		if (got.pixel_out !== e.pixel_out || got.out_row !== e.out_row ||
			got.out_col !== e.out_col || got.frame_end !== e.frame_end) begin
			fail_tally++;
			$display("%0t: expected pixel %0d row %0d col %0d end %0b,", $time,
				e.pixel_out, e.out_row, e.out_col, e.frame_end,
				" actual pixel %0d row %0d col %0d end %0b",
				got.pixel_out, got.out_row, got.out_col, got.frame_end);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = size_t'(MAX_WIDTH);
			height_reg = size_t'(MAX_HEIGHT);
			for (int i = 0; i < MAX_WIDTH; i++) begin
				older_row[i] = '0;
				recent_row[i] = '0;
			end
			win = '0;
			next_row = 0;
			next_col = 0;
			drains_owed = 0;
			fail_tally = 0;
			expected_pixels.delete();
			mismatches <= 0;
			waiting <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_item);
			// transaction accepted on the input channel
			if (in_valid && !in_stall)
				predict_item(in_item);
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WIDTH)
					width_reg = pwdata[SIZE_BITS-1:0];
				else
					height_reg = pwdata[SIZE_BITS-1:0];
				// any size write restarts the frame
				next_row = 0;
				next_col = 0;
				drains_owed = 0;
			end
			mismatches <= fail_tally;
			waiting <= expected_pixels.size();
		end
	end

endmodule

[test/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nmf_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	int unsigned          mismatches;
	int unsigned          waiting;

	int unsigned send_run;
	int unsigned recv_run;
	int unsigned stim_count;
	int unsigned taken;
	int unsigned hold;

	pixel_t corner_frame [9] = '{8'd255, 8'd0, 8'd200, 8'd17, 8'd128, 8'd255, 8'd0, 8'd1, 8'd254};

	neighbour_median_filter_3x3_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	nmf_filter_check filter_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// idle cycles before the next transaction, with occasional runs of none
	task automatic draw_idle(inout int unsigned run, output int unsigned cycles);
		if (run != 0) begin
			run--;
			cycles = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			run = $urandom_range(20, 80);
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, 16);
		end
	endtask

	function automatic pixel_t pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pixel_t'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_size(input int unsigned usual_max);
		logic [31:0] v;
		case ($urandom_range(0, 11))
			0: v = 32'd0;
			1: v = $urandom_range(1024, 2047);
			default: v = $urandom_range(1, usual_max);
		endcase
		if ($urandom_range(0, 3) == 0)
			v[31:11] = 21'($urandom);
		return v;
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer_item(input logic op, input pixel_t pix);
		int unsigned gap;
		draw_idle(send_run, gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= {op, pix};
		do @(posedge clk); while (in_stall);
	endtask

	// wait for every expected result, then for the pipeline to empty
	task automatic settle();
		int unsigned guard;
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (waiting != 0 && guard < 5000);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] raw_w, input logic [31:0] raw_h,
		input int unsigned frames, input int unsigned cut, input bit breakable);
		size_t       sw, sh;
		int unsigned w, h, total, owed, sent, stop_at;
		bit          stop;
		if ($urandom_range(0, 1)) begin
			write_reg(REG_WIDTH, raw_w);
			write_reg(REG_HEIGHT, raw_h);
		end else begin
			write_reg(REG_HEIGHT, raw_h);
			write_reg(REG_WIDTH, raw_w);
		end
		sw = raw_w[SIZE_BITS-1:0];
		sh = raw_h[SIZE_BITS-1:0];
		w = (sw == 0) ? 1 : (sw > MAX_WIDTH) ? MAX_WIDTH : sw;
		h = (sh == 0) ? 1 : (sh > MAX_HEIGHT) ? MAX_HEIGHT : sh;
		total = w * h;
		stop_at = cut;
		// big frames are only started, never finished
		if (breakable && total > 200)
			stop_at = $urandom_range(1, 60);
		stop = 1'b0;
		for (int unsigned f = 0; f < frames && !stop; f++) begin
			sent = 0;
			while (sent < total && !stop) begin
				if ($urandom_range(0, 19) == 0)
					offer_item(OP_DRAIN, pick_pixel());
				offer_item(OP_PIXEL, pick_pixel());
				sent++;
				stim_count++;
				if ((stop_at != 0 && sent >= stop_at) ||
					(breakable && $urandom_range(0, 299) == 0))
					stop = 1'b1;
			end
			if (!stop) begin
				owed = (total < w + 1) ? total : w + 1;
				for (int unsigned d = 0; d < owed && !stop; d++) begin
					// pixels are dropped while drain outputs are owed
					if ($urandom_range(0, 5) == 0)
						offer_item(OP_PIXEL, pick_pixel());
					offer_item(OP_DRAIN, pick_pixel());
					stim_count++;
					if (breakable && $urandom_range(0, 199) == 0)
						stop = 1'b1;
				end
				if (!stop && $urandom_range(0, 3) == 0)
					offer_item(OP_DRAIN, pick_pixel());
			end
		end
		settle();
	endtask

	initial begin
		out_stall <= 1'b0;
		recv_run = 0;
		taken = 0;
		@(posedge clk);
		forever begin
			draw_idle(recv_run, hold);
			// one long hold so the pipeline backs up and stalls the input
			if (taken == 100)
				hold = 300;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid || out_stall);
			taken++;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_run = 0;
		stim_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_WIDTH, 32'd3);
		write_reg(REG_HEIGHT, 32'd3);
		offer_item(OP_DRAIN, 8'hA5);
		foreach (corner_frame[i])
			offer_item(OP_PIXEL, corner_frame[i]);
		offer_item(OP_PIXEL, 8'h5A);
		repeat (4) offer_item(OP_DRAIN, 8'h00);
		offer_item(OP_DRAIN, 8'hFF);
		settle();

		// single row shorter than width+1: all outputs come from drains
		run_phase(32'hFFFF_F805, 32'd1, 1, 0, 1'b0);
		// width field reads zero, used as one
		run_phase(32'h0000_0800, 32'd2, 2, 0, 1'b0);
		// widest line, height zero used as one, cut short before any output is due
		run_phase(32'h0000_07FF, 32'd0, 1, 300, 1'b0);
		// tallest frame, cut short and restarted by the next write
		run_phase(32'd1, 32'd1024, 1, 40, 1'b0);

		while (stim_count < 1000)
			run_phase(pick_size(12), pick_size(6), $urandom_range(1, 3), 0, 1'b1);

		settle();
		if (mismatches == 0 && waiting == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

[neighbour_median_filter_3x3_unit.f]
hw/rtl/nmf_pkg.sv
hw/rtl/neighbour_median_filter_3x3_unit.sv
test/nmf_filter_check.sv
test/tb_top.sv
